/* design/bffa_pkg.sv */
// Shared types and constants for the bitmap first-fit allocator.
// Request/response payload structs, status and command codes, widths.
// No dependencies.
package bffa_pkg;

    localparam int MAX_CHUNKS_DEF = 256;
    localparam int CHUNK_BYTES    = 16;
    localparam int CHUNK_SHIFT    = $clog2(CHUNK_BYTES);
    localparam int HDR_BYTES      = 4;

    localparam int REQ_W    = 13;
    localparam int OFF_W    = 12;
    localparam int CFG_W    = 9;
    localparam int NEED_W   = REQ_W + 1 - CHUNK_SHIFT;
    localparam int OSTART_W = OFF_W - CHUNK_SHIFT;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_NO_RUN   = 2'd2,
        ST_BAD_FREE = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd             cmd;
        logic [REQ_W-1:0] request_bytes;
        logic [OFF_W-1:0] release_offset;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [OFF_W-1:0] grant_offset;
    } t_rsp;

endpackage

/* design/bffa_cell.sv */
// One chunk of the allocator pool: used bit, run-start mark and run length.
// Passes the scan token to its neighbor each cycle. Depends on bffa_pkg.
module bffa_cell #(
    parameter int IDX = 0,
    parameter int IW  = 8,
    parameter int CW  = 9,
    parameter int EW  = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bffa_pkg::t_cmd i_cmd,
    input  logic [CW-1:0] i_need,
    input  logic [CW-1:0] i_count,
    input  logic [IW-1:0] i_target,
    input  logic          i_found,
    input  logic [CW-1:0] i_run,
    input  logic [IW-1:0] i_start,
    output logic          o_found,
    output logic [CW-1:0] o_run,
    output logic [IW-1:0] o_start,
    input  logic          i_upd_set,
    input  logic          i_upd_clr,
    input  logic [IW-1:0] i_upd_start,
    input  logic [EW-1:0] i_upd_end,
    input  logic [CW-1:0] i_upd_len
);
    import bffa_pkg::*;

    localparam logic [IW-1:0] IDX_I  = IW'(IDX);
    localparam logic [IW-1:0] NEXT_I = IW'(IDX + 1);
    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [EW-1:0] IDX_E  = EW'(IDX);

    logic          r_used, n_used;
    logic          r_mark, n_mark;
    logic [CW-1:0] r_len;
    logic          r_found, n_found;
    logic [CW-1:0] r_run, n_run;
    logic [IW-1:0] r_start, n_start;
    logic          in_range;
    logic          at_start;
    logic [CW-1:0] run_inc;

    assign run_inc  = i_run + CW'(1);
    assign in_range = (IDX_I >= i_upd_start) && (IDX_E < i_upd_end);
    assign at_start = (IDX_I == i_upd_start);

    // token step
    always_comb begin
        n_found = i_found;
        n_run   = i_run;
        n_start = i_start;
        if (i_cmd == CMD_ALLOC) begin
            if (!i_found) begin
                if (r_used || (IDX_C >= i_count)) begin
                    // blocked: restart the run just past this chunk
                    n_run   = '0;
                    n_start = NEXT_I;
                end else begin
                    n_run   = run_inc;
                    n_found = (run_inc == i_need);
                end
            end
        end else begin
            if ((IDX_I == i_target) && r_mark) begin
                n_found = 1'b1;
                n_run   = r_len;
            end
        end
    end

    always_comb begin
        n_used = r_used;
        n_mark = r_mark;
        if (i_upd_set) begin
            n_used = r_used | in_range;
            n_mark = r_mark | at_start;
        end else if (i_upd_clr) begin
            n_used = r_used & ~in_range;
            n_mark = r_mark & ~at_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_mark <= 1'b0;
        end else begin
            r_used <= n_used;
            r_mark <= n_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found <= n_found;
        r_run   <= n_run;
        r_start <= n_start;
        if (i_upd_set && at_start) begin
            r_len <= i_upd_len;
        end
    end

    assign o_found = r_found;
    assign o_run   = r_run;
    assign o_start = r_start;

endmodule

/* design/bitmap_first_fit_allocator.sv */
// Top level of the bitmap first-fit allocator: request decode, scan control,
// response register and the chain of chunk cells. Depends on bffa_pkg, bffa_cell.
//
// Usage:
//  Request channel (i_req_valid/o_req_ready, payload i_req): an allocate asks
//  for request_bytes; a free names an offset returned earlier. Response channel
//  (o_rsp_valid/i_rsp_ready, payload o_rsp) gives one response per request.
//  i_cfg_we/i_cfg_wdata write the chunk count; write only while idle.
//  One request is handled at a time. Zero-size allocates, allocates larger than
//  the pool and malformed free offsets skip the scan and go straight to S_RES.
//  Every other request walks a scan token through the chain of MAX_CHUNKS
//  cells, one cell per cycle, then marks or clears the run in S_UPD and passes
//  its result through S_RES to the response register; the next request is
//  taken once the block is back in S_IDLE.
//  The response register frees the core: a held response does not stop the
//  next scan, but a finished result waits while the receiver stalls.
//  Reset (synchronous, active low) frees every chunk, clears all run marks and
//  sets the chunk count to 256.
module bitmap_first_fit_allocator #(
    parameter int MAX_CHUNKS = bffa_pkg::MAX_CHUNKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  bffa_pkg::t_req              i_req,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output bffa_pkg::t_rsp              o_rsp,
    input  logic                        i_cfg_we,
    input  logic [bffa_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import bffa_pkg::*;

    localparam int IW = $clog2(MAX_CHUNKS);
    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam int EW = CW + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_UPD  = 4'b0100,
        S_RES  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [IW-1:0]    r_cnt, n_cnt;
    t_cmd             r_cmd, n_cmd;
    logic [CW-1:0]    r_need, n_need;
    logic [CW-1:0]    r_count, n_count;
    logic [IW-1:0]    r_target, n_target;
    t_status          r_res_status, n_res_status;
    logic [OFF_W-1:0] r_res_grant, n_res_grant;
    logic [CFG_W-1:0] r_cfg;
    logic             r_out_vld, n_out_vld;
    t_rsp             r_out, n_out;

    logic              req_acc;
    logic [CW-1:0]     active;
    logic [REQ_W:0]    need_sum;
    logic [NEED_W-1:0] need;
    logic [OFF_W-1:0]  rel;
    logic [OSTART_W-1:0] off_start;
    logic              upd_set, upd_clr;
    logic [IW-1:0]     upd_start;
    logic [CW-1:0]     upd_len;
    logic [EW-1:0]     upd_end;

    logic          tok_found [MAX_CHUNKS+1];
    logic [CW-1:0] tok_run   [MAX_CHUNKS+1];
    logic [IW-1:0] tok_start [MAX_CHUNKS+1];

    assign o_req_ready = (r_state == S_IDLE);
    assign req_acc     = i_req_valid && o_req_ready;

    assign active    = (32'(r_cfg) > MAX_CHUNKS) ? CW'(MAX_CHUNKS) : CW'(r_cfg);
    assign need_sum  = {1'b0, i_req.request_bytes} + (REQ_W+1)'(HDR_BYTES + CHUNK_BYTES - 1);
    assign need      = need_sum[REQ_W:CHUNK_SHIFT];
    assign rel       = i_req.release_offset - OFF_W'(HDR_BYTES);
    assign off_start = rel[OFF_W-1:CHUNK_SHIFT];

    // run update driven in the cycle after the scan completes
    always_comb begin
        upd_set   = 1'b0;
        upd_clr   = 1'b0;
        upd_start = r_target;
        upd_len   = tok_run[MAX_CHUNKS];
        if (r_state == S_UPD && tok_found[MAX_CHUNKS]) begin
            if (r_cmd == CMD_ALLOC) begin
                upd_set   = 1'b1;
                upd_start = tok_start[MAX_CHUNKS];
                upd_len   = r_need;
            end else begin
                upd_clr   = 1'b1;
            end
        end
    end
    assign upd_end = EW'(upd_start) + EW'(upd_len);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_cmd        = r_cmd;
        n_need       = r_need;
        n_count      = r_count;
        n_target     = r_target;
        n_res_status = r_res_status;
        n_res_grant  = r_res_grant;
        n_out_vld    = r_out_vld;
        n_out        = r_out;

        if (o_rsp_valid && i_rsp_ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_cmd       = i_req.cmd;
                    n_count     = active;
                    n_cnt       = '0;
                    n_res_grant = '0;
                    n_state     = S_SCAN;
                    if (i_req.cmd == CMD_ALLOC) begin
                        n_need = CW'(need);
                        if (i_req.request_bytes == '0) begin
                            n_res_status = ST_ZERO;
                            n_state      = S_RES;
                        end else if (32'(need) > 32'(active)) begin
                            n_res_status = ST_NO_RUN;
                            n_state      = S_RES;
                        end
                    end else begin
                        n_target = IW'(32'(off_start));
                        if ((i_req.release_offset < OFF_W'(HDR_BYTES)) ||
                            (rel[CHUNK_SHIFT-1:0] != '0) ||
                            (32'(off_start) >= MAX_CHUNKS)) begin
                            n_res_status = ST_BAD_FREE;
                            n_state      = S_RES;
                        end
                    end
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + IW'(1);
                if (r_cnt == IW'(MAX_CHUNKS - 1)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_res_grant = '0;
                if (!tok_found[MAX_CHUNKS]) begin
                    n_res_status = (r_cmd == CMD_ALLOC) ? ST_NO_RUN : ST_BAD_FREE;
                end else begin
                    n_res_status = ST_OK;
                    if (r_cmd == CMD_ALLOC) begin
                        n_res_grant = OFF_W'(32'(tok_start[MAX_CHUNKS]) << CHUNK_SHIFT)
                                    | OFF_W'(HDR_BYTES);
                    end
                end
                n_state = S_RES;
            end
            S_RES: begin
                // hold until the response register is free
                if (!r_out_vld || i_rsp_ready) begin
                    n_out_vld          = 1'b1;
                    n_out.status       = r_res_status;
                    n_out.grant_offset = r_res_grant;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_cfg     <= CFG_RESET;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_cmd        <= n_cmd;
        r_need       <= n_need;
        r_count      <= n_count;
        r_target     <= n_target;
        r_res_status <= n_res_status;
        r_res_grant  <= n_res_grant;
        r_out        <= n_out;
    end

    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;

    // scan token enters the chain empty
    assign tok_found[0] = 1'b0;
    assign tok_run[0]   = '0;
    assign tok_start[0] = '0;

    for (genvar g = 0; g < MAX_CHUNKS; g++) begin : g_cell
        bffa_cell #(
            .IDX (g),
            .IW  (IW),
            .CW  (CW),
            .EW  (EW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (r_cmd),
            .i_need      (r_need),
            .i_count     (r_count),
            .i_target    (r_target),
            .i_found     (tok_found[g]),
            .i_run       (tok_run[g]),
            .i_start     (tok_start[g]),
            .o_found     (tok_found[g+1]),
            .o_run       (tok_run[g+1]),
            .o_start     (tok_start[g+1]),
            .i_upd_set   (upd_set),
            .i_upd_clr   (upd_clr),
            .i_upd_start (upd_start),
            .i_upd_end   (upd_end),
            .i_upd_len   (upd_len)
        );
    end

endmodule

/* design/bffa_checker.sv */
// Port-level checks for the bitmap first-fit allocator, bound to the top level.
// Depends on bffa_pkg and bitmap_first_fit_allocator.
module bffa_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_req_valid,
    input logic                       o_req_ready,
    input logic                       o_rsp_valid,
    input logic                       i_rsp_ready,
    input bffa_pkg::t_rsp             o_rsp
);
    import bffa_pkg::*;

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response dropped or changed while stalled");

    // only one request in flight
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while another is in flight");

    a_err_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != ST_OK |-> o_rsp.grant_offset == '0)
        else $error("grant offset set on an error response");

    // a grant points just past a chunk header
    a_grant_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.grant_offset != '0 |->
            o_rsp.status == ST_OK &&
            o_rsp.grant_offset[CHUNK_SHIFT-1:0] == CHUNK_SHIFT'(HDR_BYTES))
        else $error("grant offset not aligned to a chunk header");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid && o_req_ready)
        else $error("block not idle after reset");

endmodule

bind bitmap_first_fit_allocator bffa_checker u_bffa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);
